/* rtl/core/integer_matrix_multiply_macros.svh */
// Assertion helpers for the checker file.
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define IMM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_matrix_multiply: check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define IMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_matrix_multiply: check failed");

`endif

/* rtl/core/imm_pkg.sv */
package imm_pkg;

    // Request kinds carried in s_tuser.
    typedef enum logic [1:0] {
        KIND_LOAD_A  = 2'd0,
        KIND_LOAD_B  = 2'd1,
        KIND_COMPUTE = 2'd2
    } kind_t;

    // Configuration register indexes.
    localparam logic REG_ROWS  = 1'b0;
    localparam logic REG_INNER = 1'b1;

    localparam int REG_W    = 4;
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 16;
    localparam int PROD_W   = 32;
    localparam int ROW_W    = 3;
    localparam int COL_W    = 3;
    // 16x16 products summed over up to eight terms
    localparam int ACC_W    = 35;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam int IN_INDEX_LSB  = 0;
    localparam int IN_VALUE_LSB  = IN_INDEX_LSB + INDEX_W;
    localparam int OUT_PROD_LSB  = 0;
    localparam int OUT_ROW_LSB   = OUT_PROD_LSB + PROD_W;
    localparam int OUT_COL_LSB   = OUT_ROW_LSB + ROW_W;
    localparam int OUT_PAD_LSB   = OUT_COL_LSB + COL_W;

    // Control that travels alongside each multiply-accumulate step.
    typedef struct packed {
        logic             first;
        logic             dot_end;
        logic             frame_end;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } mac_tag_t;

endpackage

/* rtl/core/integer_matrix_multiply.sv */
// Load requests (A or B element) are accepted one per cycle while no compute is in progress.
// Compute: one multiply-accumulate per cycle from the two store read ports; the input
// stays closed until all m*m*n steps are issued, and each step passes through read,
// multiply and accumulate into the output register. Output stalls hold the pipeline.
// Reset clears control, sets rows=2 and inner=3; store contents are not cleared.
module integer_matrix_multiply
    import imm_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // index[5:0], value[21:6], zero pad
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // product[31:0], row[34:32], col[37:35], pad
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [REG_W-1:0]      cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    // configuration
    logic [REG_W-1:0] rows_reg;
    logic [REG_W-1:0] inner_reg;
    logic [REG_W-1:0] rows_clamped;
    logic [REG_W-1:0] inner_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= REG_W'(2);
            inner_reg <= REG_W'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS:  rows_reg  <= cfg_data;
                REG_INNER: inner_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        priority if (rows_reg == '0)
            rows_clamped = REG_W'(1);
        else if (rows_reg > REG_W'(MAX_DIM))
            rows_clamped = REG_W'(MAX_DIM);
        else
            rows_clamped = rows_reg;

        priority if (inner_reg == '0)
            inner_clamped = REG_W'(1);
        else if (inner_reg > REG_W'(MAX_DIM))
            inner_clamped = REG_W'(MAX_DIM);
        else
            inner_clamped = inner_reg;
    end

    // input request decode
    logic               in_fire;
    logic [INDEX_W-1:0] in_index;
    logic [VALUE_W-1:0] in_value;
    logic               in_index_ok;
    logic               we_left;
    logic               we_right;
    logic               start;

    assign in_fire     = s_tvalid && s_tready;
    assign in_index    = s_tdata[IN_INDEX_LSB +: INDEX_W];
    assign in_value    = s_tdata[IN_VALUE_LSB +: VALUE_W];
    assign in_index_ok = ({1'b0, in_index} < (INDEX_W + 1)'(DEPTH));

    always_comb
    begin
        we_left  = 1'b0;
        we_right = 1'b0;
        start    = 1'b0;
        if (in_fire)
        begin
            unique case (s_tuser)
                KIND_LOAD_A:  we_left  = in_index_ok;
                KIND_LOAD_B:  we_right = in_index_ok;
                KIND_COMPUTE: start    = 1'b1;
                default:      ;
            endcase
        end
    end

    // pipeline advance: everything holds while the output register is stuck
    logic advance;
    assign advance = !m_tvalid || m_tready;

    // issue sequencer
    logic              busy_reg,     busy_next;
    logic [REG_W-1:0]  m_reg,        m_next;
    logic [REG_W-1:0]  n_reg,        n_next;
    logic [CW-1:0]     r_reg,        r_next;
    logic [CW-1:0]     c_reg,        c_next;
    logic [CW-1:0]     k_reg,        k_next;
    logic [AW-1:0]     a_addr_reg,   a_addr_next;
    logic [AW-1:0]     b_addr_reg,   b_addr_next;
    logic [AW-1:0]     row_base_reg, row_base_next;
    logic              k_end;
    logic              c_end;
    logic              r_end;
    logic              issue;
    mac_tag_t          issue_tag;

    assign k_end = (REG_W'(k_reg) == n_reg - REG_W'(1));
    assign c_end = (REG_W'(c_reg) == m_reg - REG_W'(1));
    assign r_end = (REG_W'(r_reg) == m_reg - REG_W'(1));
    assign issue = busy_reg && advance;

    always_comb
    begin
        issue_tag.first     = (k_reg == '0);
        issue_tag.dot_end   = k_end;
        issue_tag.frame_end = k_end && c_end && r_end;
        issue_tag.row       = ROW_W'(r_reg);
        issue_tag.col       = COL_W'(c_reg);
    end

    always_comb
    begin
        busy_next     = busy_reg;
        m_next        = m_reg;
        n_next        = n_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        k_next        = k_reg;
        a_addr_next   = a_addr_reg;
        b_addr_next   = b_addr_reg;
        row_base_next = row_base_reg;
        if (start)
        begin
            busy_next     = 1'b1;
            m_next        = rows_clamped;
            n_next        = inner_clamped;
            r_next        = '0;
            c_next        = '0;
            k_next        = '0;
            a_addr_next   = '0;
            b_addr_next   = '0;
            row_base_next = '0;
        end
        else if (issue)
        begin
            if (!k_end)
            begin
                k_next      = k_reg + CW'(1);
                a_addr_next = a_addr_reg + AW'(1);
                b_addr_next = b_addr_reg + AW'(m_reg);
            end
            else
            begin
                k_next = '0;
                if (!c_end)
                begin
                    c_next      = c_reg + CW'(1);
                    a_addr_next = row_base_reg;
                    b_addr_next = AW'(c_reg) + AW'(1);
                end
                else
                begin
                    c_next      = '0;
                    b_addr_next = '0;
                    if (r_end)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        r_next        = r_reg + CW'(1);
                        row_base_next = row_base_reg + AW'(n_reg);
                        a_addr_next   = row_base_reg + AW'(n_reg);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg        <= m_next;
        n_reg        <= n_next;
        r_reg        <= r_next;
        c_reg        <= c_next;
        k_reg        <= k_next;
        a_addr_reg   <= a_addr_next;
        b_addr_reg   <= b_addr_next;
        row_base_reg <= row_base_next;
    end

    assign s_tready = !busy_reg;

    // element stores
    logic [VALUE_W-1:0] a_rdata;
    logic [VALUE_W-1:0] b_rdata;

    imm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_left_store (
        .clk   (clk),
        .we    (we_left),
        .waddr (in_index[AW-1:0]),
        .wdata (in_value),
        .re    (issue),
        .raddr (a_addr_reg),
        .rdata (a_rdata)
    );

    imm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_right_store (
        .clk   (clk),
        .we    (we_right),
        .waddr (in_index[AW-1:0]),
        .wdata (in_value),
        .re    (issue),
        .raddr (b_addr_reg),
        .rdata (b_rdata)
    );

    // read -> multiply -> accumulate -> output
    logic                     s1_valid_reg;
    mac_tag_t                 s1_tag_reg;
    logic                     s2_valid_reg;
    mac_tag_t                 s2_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic [PROD_W-1:0]        sat_value;
    logic                     out_valid_reg, out_valid_next;
    logic [PROD_W-1:0]        out_prod_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic [COL_W-1:0]         out_col_reg;
    logic                     out_last_reg;
    logic                     out_load;

    assign acc_next = (s2_tag_reg.first ? ACC_W'(0) : acc_reg)
                    + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        priority if (acc_next[ACC_W-1:PROD_W-1] == '0
                     || acc_next[ACC_W-1:PROD_W-1] == '1)
            sat_value = acc_next[PROD_W-1:0];
        else if (acc_next[ACC_W-1])
            sat_value = {1'b1, {(PROD_W - 1){1'b0}}};
        else
            sat_value = {1'b0, {(PROD_W - 1){1'b1}}};
    end

    assign out_load = advance && s2_valid_reg && s2_tag_reg.dot_end;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_tag_reg <= issue_tag;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= $signed(a_rdata) * $signed(b_rdata);
            if (s2_valid_reg)
            begin
                acc_reg <= acc_next;
            end
        end
        if (out_load)
        begin
            out_prod_reg <= sat_value;
            out_row_reg  <= s2_tag_reg.row;
            out_col_reg  <= s2_tag_reg.col;
            out_last_reg <= s2_tag_reg.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_PAD_LSB){1'b0}},
                       out_col_reg, out_row_reg, out_prod_reg};

endmodule

/* rtl/core/imm_ram.sv */
module imm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/imm_checker.sv */
`include "integer_matrix_multiply_macros.svh"

module imm_checker
    import imm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [KIND_W-1:0]     s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;

    assign out_row = m_tdata[OUT_ROW_LSB +: ROW_W];
    assign out_col = m_tdata[OUT_COL_LSB +: COL_W];

    // a stalled result holds
    `IMM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // a compute request closes the input until its issue is done
    `IMM_ASSERT_NEXT(a_compute_busy, clk, rst_n,
        s_tvalid && s_tready && s_tuser == KIND_COMPUTE, !s_tready)

    // the final result sits on the diagonal corner of a square product
    `IMM_ASSERT_NOW(a_last_corner, clk, rst_n, m_tvalid && m_tlast,
        out_row == ROW_W'(out_col))

    // after the final result the next one opens a new product at the origin
    `IMM_ASSERT_NEXT(a_frame_restart, clk, rst_n, m_tvalid && m_tready && m_tlast,
        !m_tvalid || (out_row == '0 && out_col == '0))

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (.*);
